// ===== rtl/mlbr_pkg.sv =====
`timescale 1ns / 1ps
package mlbr_pkg;

  localparam int NUM_CH     = 4;
  localparam int CH_W       = 8;
  localparam int SUM_W      = CH_W + 1;
  localparam int SRC_W_BITS = 13;
  localparam int SRC_H_BITS = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

  typedef logic [NUM_CH-1:0][CH_W-1:0]  pix_t;
  typedef logic [NUM_CH-1:0][SUM_W-1:0] pair_t;

  // per-transaction decisions from the raster position
  typedef struct packed {
    logic hold_left;
    logic store_row;
    logic emit;
    logic dbl_h;
    logic dbl_v;
    logic last;
  } ctrl_t;

endpackage

// ===== rtl/mlbr_pix_if.sv =====
`timescale 1ns / 1ps
interface mlbr_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// ===== rtl/mlbr_res_if.sv =====
`timescale 1ns / 1ps
interface mlbr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       level_done;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, level_done,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, level_done,
                  output ready);
endinterface

// ===== rtl/mlbr_line_store.sv =====
`timescale 1ns / 1ps
module mlbr_line_store import mlbr_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  pair_t         wdata,
  output pair_t         rdata
);

  pair_t mem [DEPTH];
  pair_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/mlbr_raster_ctrl.sv =====
`timescale 1ns / 1ps
module mlbr_raster_ctrl import mlbr_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 16384,
  parameter int AW         = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  accept,
  output ctrl_t                 ctrl,
  output logic [AW-1:0]         line_idx
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [WW-1:0] pw_r, pw_nxt, pw_cand;
  logic [HW-1:0] ph_r, ph_nxt, ph_cand;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [31:0]   wv, hv;
  logic          pw1, ph1, col_last, row_last, have_pair;
  logic [WW-1:0] cw_m1, col_half;
  logic [HW-1:0] ch_m1, row_half;

  always_comb begin
    wv = 32'(cfg_wdata[SRC_W_BITS-1:0]);
    hv = 32'(cfg_wdata[SRC_H_BITS-1:0]);
    if (wv == 32'd0) begin
      pw_cand = WW'(1);
    end else if (wv > 32'(MAX_WIDTH)) begin
      pw_cand = WW'(MAX_WIDTH);
    end else begin
      pw_cand = WW'(wv);
    end
    if (hv == 32'd0) begin
      ph_cand = HW'(1);
    end else if (hv > 32'(MAX_HEIGHT)) begin
      ph_cand = HW'(MAX_HEIGHT);
    end else begin
      ph_cand = HW'(hv);
    end
  end

  always_comb begin
    pw_nxt = pw_r;
    ph_nxt = ph_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  pw_nxt = pw_cand;
        REG_SOURCE_HEIGHT: ph_nxt = ph_cand;
        default: ;
      endcase
    end
  end

  always_comb begin
    pw1       = (pw_r == WW'(1));
    ph1       = (ph_r == HW'(1));
    col_last  = (WW'(col_r) == pw_r - WW'(1));
    row_last  = (HW'(row_r) == ph_r - HW'(1));
    cw_m1     = pw1 ? '0 : WW'((pw_r >> 1) - WW'(1));
    ch_m1     = ph1 ? '0 : HW'((ph_r >> 1) - HW'(1));
    col_half  = WW'(col_r) >> 1;
    row_half  = HW'(row_r) >> 1;
    have_pair = pw1 | col_r[0];

    ctrl.hold_left = ~pw1 & ~col_r[0];
    ctrl.store_row = have_pair & ~ph1 & ~row_r[0];
    ctrl.emit      = have_pair & (ph1 | row_r[0]);
    ctrl.dbl_h     = pw1;
    ctrl.dbl_v     = ph1;
    ctrl.last      = (col_half == cw_m1) && (row_half == ch_m1);
    line_idx       = AW'(col_r >> 1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : RW'(row_r + RW'(1));
      end else begin
        col_nxt = CW'(col_r + CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r  <= WW'(1);
      ph_r  <= HW'(1);
      col_r <= '0;
      row_r <= '0;
    end else begin
      pw_r  <= pw_nxt;
      ph_r  <= ph_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (col_r == '0) && (row_r == '0))
    else $error("position not cleared by register write");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < pw_r)
    else $error("column beyond source width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    HW'(row_r) < ph_r)
    else $error("row beyond source height");

endmodule

// ===== rtl/mip_level_box_reducer_unit.sv =====
`timescale 1ns / 1ps
// A block's result is registered in stage 1 from its last pixel, then in the output register.
// Throughput: 1 pixel/cycle unless output stalls; at most one result per 2 (pw>1) pixels.
// Line store read is registered, so the vertical add sits one stage after input.
// Reset: synchronous, active low; width and height return to 1, raster position to 0.
// Line store contents are not cleared; an odd row only reads entries its even row wrote.
module mip_level_box_reducer_unit import mlbr_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 16384
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mlbr_pix_if.sink              in_pix,
  mlbr_res_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  ctrl_t          ctrl;
  logic [AW-1:0]  line_idx;
  logic           accept, adv, in_ready;
  pix_t           px, held_r;
  pair_t          pair_nxt, mem_q;
  logic           s1_valid_r, s1_valid_nxt, s1_dbl_v_r, s1_last_r;
  pair_t          s1_pair_r;
  logic           out_valid_r, out_valid_nxt, out_last_r;
  pix_t           out_pix_r, out_pix_nxt;
  logic [SUM_W:0] total [NUM_CH];

  assign px       = {in_pix.alpha, in_pix.blue, in_pix.green, in_pix.red};
  assign adv      = ~out_valid_r | out_res.ready;
  assign in_ready = ~s1_valid_r | adv;
  assign accept   = in_pix.valid & in_ready;

  assign in_pix.ready = in_ready;

  mlbr_raster_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .ctrl      (ctrl),
    .line_idx  (line_idx)
  );

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pair_nxt[c] = ctrl.dbl_h ? {px[c], 1'b0}
                               : SUM_W'({1'b0, held_r[c]} + {1'b0, px[c]});
    end
  end

  mlbr_line_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line (
    .clk   (clk),
    .we    (accept & ctrl.store_row),
    .re    (accept & ctrl.emit & ~ctrl.dbl_v),
    .addr  (line_idx),
    .wdata (pair_nxt),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (accept && ctrl.hold_left) begin
      held_r <= px;
    end
    if (accept && ctrl.emit) begin
      s1_pair_r  <= pair_nxt;
      s1_dbl_v_r <= ctrl.dbl_v;
      s1_last_r  <= ctrl.last;
    end
    if (adv && s1_valid_r) begin
      out_pix_r  <= out_pix_nxt;
      out_last_r <= s1_last_r;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      total[c] = s1_dbl_v_r ? {s1_pair_r[c], 1'b0}
                            : (SUM_W + 1)'({1'b0, mem_q[c]} + {1'b0, s1_pair_r[c]});
      out_pix_nxt[c] = total[c][SUM_W:2];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept && ctrl.emit) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.out_red    = out_pix_r[0];
  assign out_res.out_green  = out_pix_r[1];
  assign out_res.out_blue   = out_pix_r[2];
  assign out_res.out_alpha  = out_pix_r[3];
  assign out_res.level_done = out_last_r;

  a_emit_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ctrl.emit |=> s1_valid_r)
    else $error("emitting transaction lost before output stage");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_res.ready)
    else $error("input stalled with room in the pipeline");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_pair_r))
    else $error("stalled stage changed");

endmodule
